// File: src/irc_pkg.sv
package irc_pkg;

  // Sizes
  localparam int unsigned VALUE_BITS = 63;
  localparam int unsigned MAX_DIGITS = 64;
  localparam int unsigned BASE_W     = 6;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

  // Digit store: two banks, one being filled while the other drains
  localparam int unsigned BANKS      = 2;
  localparam int unsigned RAM_DEPTH  = BANKS * MAX_DIGITS;
  localparam int unsigned RAM_AW     = $clog2(RAM_DEPTH);

  // Job queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Stream widths, padded to whole bytes
  localparam int unsigned S_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W  = ((CHAR_W + 7) / 8) * 8;

  // Constants
  localparam logic [BASE_W-1:0]  BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0]  BASE_MAX   = BASE_W'(36);
  localparam logic [BASE_W-1:0]  BASE_RESET = BASE_W'(2);
  localparam logic [DIGIT_W-1:0] DEC_TEN    = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_NINE = CHAR_W'(57);
  localparam logic [CHAR_W-1:0]  ASCII_A    = CHAR_W'(65);
  localparam logic [CHAR_W-1:0]  ASCII_Z    = CHAR_W'(90);

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [DIGIT_W-1:0] data;
  } ram_wr_t;

  typedef enum logic {
    F_IDLE,
    F_DIV
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOAD,
    B_SEND
  } back_state_e;

  // Clamp the register value into the supported radix range
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_TEN) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d) - CHAR_W'(DEC_TEN);
    end
    return c;
  endfunction

  // Digit store address of one entry in one bank
  function automatic logic [RAM_AW-1:0] ram_addr(input logic bank,
                                                 input logic [DIG_IDX_W-1:0] idx);
    logic [RAM_AW-1:0] a;
    a = RAM_AW'(idx) + (bank ? RAM_AW'(MAX_DIGITS) : RAM_AW'(0));
    return a;
  endfunction

endpackage

// File: src/irc_ram.sv
module irc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/irc_job_fifo.sv
module irc_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  irc_pkg::job_t job_i,
  input  logic          pop_i,
  output irc_pkg::job_t job_o,
  output logic          empty_o,
  output logic          full_o
);

  import irc_pkg::*;

  job_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o   = entry_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));

endmodule

// File: src/irc_front.sv
module irc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [irc_pkg::BASE_W-1:0]        base_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [irc_pkg::VALUE_BITS-1:0]    in_value_i,
  output irc_pkg::ram_wr_t                  ram_wr_o,
  input  logic                              fifo_full_i,
  output logic                              push_o,
  output irc_pkg::job_t                     job_o
);

  import irc_pkg::*;

  front_state_e           state_q, state_d;
  logic [VALUE_BITS-1:0]  val_q, val_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [BASE_W-1:0]      base_q, base_d;
  logic [BIT_CNT_W-1:0]   bit_q, bit_d;
  logic [CNT_W-1:0]       num_q, num_d;
  logic                   bank_q, bank_d;

  logic [DIGIT_W:0]       trial;
  logic                   ge;
  logic [DIGIT_W-1:0]     rem_new;
  logic [VALUE_BITS-1:0]  val_new;
  logic                   last_bit;

  // One restoring division step per cycle, quotient shifts in at the bottom
  assign trial    = {rem_q, val_q[VALUE_BITS-1]};
  assign ge       = (trial >= {1'b0, base_q});
  assign rem_new  = ge ? DIGIT_W'(trial - {1'b0, base_q}) : trial[DIGIT_W-1:0];
  assign val_new  = {val_q[VALUE_BITS-2:0], ge};
  assign last_bit = (bit_q == BIT_CNT_W'(VALUE_BITS - 1));

  assign in_ready_o = (state_q == F_IDLE) && !fifo_full_i;

  // Next state: accept a value, then divide digit after digit
  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    rem_d       = rem_q;
    base_d      = base_q;
    bit_d       = bit_q;
    num_d       = num_q;
    bank_d      = bank_q;
    ram_wr_o    = '0;
    push_o      = 1'b0;
    job_o.bank  = bank_q;
    job_o.count = num_q + 1'b1;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          val_d   = in_value_i;
          base_d  = clamp_base(base_i);
          rem_d   = '0;
          bit_d   = '0;
          num_d   = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        val_d = val_new;
        if (last_bit) begin
          // Store the remainder as the next digit, least significant first
          ram_wr_o.we   = 1'b1;
          ram_wr_o.addr = ram_addr(bank_q, num_q[DIG_IDX_W-1:0]);
          ram_wr_o.data = rem_new;
          num_d         = num_q + 1'b1;
          rem_d         = '0;
          bit_d         = '0;
          if (val_new == '0 || num_q == CNT_W'(MAX_DIGITS - 1)) begin
            push_o  = 1'b1;
            bank_d  = ~bank_q;
            state_d = F_IDLE;
          end
        end else begin
          rem_d = rem_new;
          bit_d = bit_q + 1'b1;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      bank_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    base_q <= base_d;
    bit_q  <= bit_d;
    num_q  <= num_d;
  end

endmodule

// File: src/irc_back.sv
module irc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fifo_empty_i,
  input  irc_pkg::job_t                  job_i,
  output logic                           pop_o,
  output logic                           ram_re_o,
  output logic [irc_pkg::RAM_AW-1:0]     ram_raddr_o,
  input  logic [irc_pkg::DIGIT_W-1:0]    ram_rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [irc_pkg::CHAR_W-1:0]     out_char_o,
  output logic                           out_last_o
);

  import irc_pkg::*;

  back_state_e            state_q, state_d;
  logic [DIG_IDX_W-1:0]   idx_q, idx_d;
  logic [CHAR_W-1:0]      char_q, char_d;
  logic                   last_q, last_d;
  logic [DIG_IDX_W-1:0]   top_idx;

  assign top_idx = DIG_IDX_W'(job_i.count - 1'b1);

  // Walk the stored digits from most significant down
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    char_d      = char_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = ram_addr(job_i.bank, idx_q);
    out_valid_o = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!fifo_empty_i) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ram_addr(job_i.bank, top_idx);
          idx_d       = top_idx;
          state_d     = B_LOAD;
        end
      end
      B_LOAD: begin
        char_d  = digit_to_ascii(ram_rdata_i);
        last_d  = (idx_q == '0);
        state_d = B_SEND;
      end
      B_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_q) begin
            // Release the bank once its final character is taken
            pop_o   = 1'b1;
            state_d = B_IDLE;
          end else begin
            idx_d       = idx_q - 1'b1;
            ram_re_o    = 1'b1;
            ram_raddr_o = ram_addr(job_i.bank, idx_q - 1'b1);
            state_d     = B_LOAD;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_char_o = char_q;
  assign out_last_o = last_q;

endmodule

// File: src/integer_radix_conversion.sv
// Integer to base-N ASCII converter.
// Program the radix through cfg_we_i / cfg_wdata_i (2..36; 0 and 1 act as 2,
// 37..63 act as 36) while the block is idle. Each request on the s_axis side
// carries one unsigned 63-bit value in tdata[62:0]. The m_axis side returns
// its digits as ASCII ('0'-'9', 'A'-'Z'), most significant first, one per
// transfer in tdata[6:0], with tlast on the final digit. Zero yields "0".
// The front divides one quotient bit per cycle and stores each remainder as
// the next digit; a value occupies the divider until its last digit is
// stored. Each character is read from the digit store and registered
// before it is offered, and the next digit is read only once the
// receiver has taken the current one.
// Two digit banks and a two-entry job queue let the divider take the next
// value while the previous one is still being emitted; s_axis_tready drops
// while dividing and while both banks hold unsent digits.
// A stalled receiver holds the current character and its tlast stable.
// Reset sets the radix to 2 and empties the queue; no clearing pass needed.
module integer_radix_conversion (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [irc_pkg::BASE_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [irc_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,  // [62:0] value
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [irc_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,  // [6:0] digit_char
  output logic                            m_axis_tlast_o   // last_digit
);

  import irc_pkg::*;

  logic [BASE_W-1:0]  base_q;
  ram_wr_t            ram_wr;
  logic               ram_re;
  logic [RAM_AW-1:0]  ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;
  logic               fifo_push, fifo_pop, fifo_empty, fifo_full;
  job_t               push_job, head_job;
  logic [CHAR_W-1:0]  out_char;

  // Radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  irc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_i      (base_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_value_i  (s_axis_tdata_i[VALUE_BITS-1:0]),
    .ram_wr_o    (ram_wr),
    .fifo_full_i (fifo_full),
    .push_o      (fifo_push),
    .job_o       (push_job)
  );

  irc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (RAM_DEPTH)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  irc_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .job_i   (push_job),
    .pop_i   (fifo_pop),
    .job_o   (head_job),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  irc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .job_i        (head_job),
    .pop_o        (fifo_pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_char_o   (out_char),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = M_TDATA_W'(out_char);

endmodule

// File: src/irc_checker.sv
module irc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_o,
  input  logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic [irc_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                            m_axis_tlast_o
);

  import irc_pkg::*;

  // Every emitted character is a digit or an upper-case letter
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tdata_o[CHAR_W-1:0] >= ASCII_ZERO && m_axis_tdata_o[CHAR_W-1:0] <= ASCII_NINE) ||
       (m_axis_tdata_o[CHAR_W-1:0] >= ASCII_A && m_axis_tdata_o[CHAR_W-1:0] <= ASCII_Z)) &&
      (m_axis_tdata_o[M_TDATA_W-1:CHAR_W] == '0))
    else $error("character out of range");

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output changed");

  // The divider is busy right after taking a value
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready while dividing");

  // The next character needs a digit store read first
  a_gap_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |=> !m_axis_tvalid_o)
    else $error("output valid without digit read");

endmodule

bind integer_radix_conversion irc_checker u_irc_checker (.*);

// File: test/tb_integer_radix_conversion.sv
module tb_integer_radix_conversion;

  import irc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned HOLD_CYCLES = 2000;

  // One character as the block should emit it
  typedef struct packed {
    logic              last;
    logic [CHAR_W-1:0] ch;
  } digit_t;

  // Predicts the digit stream of every accepted request and checks each emitted character
  class radix_digit_board;
    logic [BASE_W-1:0] base_reg;
    digit_t            pending_digits[$];
    int                errors;
    int                values_seen;
    int                digits_checked;

    function new();
      base_reg = BASE_RESET;
      errors = 0;
      values_seen = 0;
      digits_checked = 0;
    endfunction

    // Expand one value into its characters, most significant first
    function void note_value(logic [VALUE_BITS-1:0] value);
      logic [63:0]        rem;
      logic [63:0]        radix;
      logic [63:0]        d;
      logic [DIGIT_W-1:0] stack[$];
      digit_t             item;
      rem = 64'(value);
      if (base_reg < BASE_MIN) begin
        radix = 64'(BASE_MIN);
      end else if (base_reg > BASE_MAX) begin
        radix = 64'(BASE_MAX);
      end else begin
        radix = 64'(base_reg);
      end
      while (rem != 0 && stack.size() < MAX_DIGITS) begin
        d = rem % radix;
        stack.push_front(d[DIGIT_W-1:0]);
        rem = rem / radix;
      end
      if (stack.size() == 0) begin
        stack.push_back('0);
      end
      foreach (stack[k]) begin
        if (stack[k] < DEC_TEN) begin
          item.ch = ASCII_ZERO + CHAR_W'(stack[k]);
        end else begin
          item.ch = ASCII_A + CHAR_W'(stack[k]) - CHAR_W'(DEC_TEN);
        end
        item.last = (k == stack.size() - 1);
        pending_digits.push_back(item);
      end
      values_seen++;
    endfunction

    // Compare one emitted character against the oldest prediction
    function void check_digit(logic [CHAR_W-1:0] ch, logic last);
      digit_t want;
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit, got char %0d last %0b", $time, ch, last);
        errors++;
        return;
      end
      want = pending_digits.pop_front();
      digits_checked++;
      if (ch !== want.ch) begin
        $display("%0t: digit_char mismatch, expected %0d got %0d", $time, want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_digit mismatch, expected %0b got %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [BASE_W-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;   // [62:0] value
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;   // [6:0] digit_char
  logic                 m_axis_tlast_o;   // last_digit

  radix_digit_board board = new();
  bit               no_gaps;
  int unsigned      hold_off_cycles;
  int unsigned      cycle_count = 0;
  int               bases_tried;

  integer_radix_conversion dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Record accepted requests
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      board.note_value(s_axis_tdata_i[VALUE_BITS-1:0]);
    end
  end

  // Check emitted characters
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_digit(m_axis_tdata_o[CHAR_W-1:0], m_axis_tlast_o);
    end
  end

  // Receiver: random stalls per character, plus a long hold-off on demand
  initial begin : receiver
    int gap;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Offer one value; valid stays high afterwards until the next call or a halt
  task automatic offer_value(input logic [VALUE_BITS-1:0] value);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(S_TDATA_W - VALUE_BITS){1'b0}}, value};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Drop the request and wait until every predicted character has been seen
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_digits.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Program the radix; only called while the block is idle
  task automatic set_base(input logic [BASE_W-1:0] b);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.base_reg = b;
    bases_tried++;
  endtask

  // Mostly random widths, with zero and the full-scale value mixed in
  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [63:0] raw;
    int          width;
    int          sel;
    sel = $urandom_range(0, 9);
    raw = {$urandom, $urandom};
    width = $urandom_range(1, VALUE_BITS);
    if (sel == 0) begin
      raw = '0;
    end else if (sel == 1) begin
      raw = '1;
    end else begin
      raw = raw & ((64'd1 << width) - 64'd1);
    end
    return raw[VALUE_BITS-1:0];
  endfunction

  initial begin : stimulus
    int plan[8];
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    rst_ni          <= 1'b0;
    no_gaps = 1'b0;
    hold_off_cycles = 0;
    bases_tried = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset radix: zero, one, full scale, single high bit, alternating bits
    offer_value(63'd0);
    offer_value(63'd1);
    offer_value(63'h7FFF_FFFF_FFFF_FFFF);
    offer_value(63'h4000_0000_0000_0000);
    offer_value(63'h5555_5555_5555_5555);
    wait_drained();

    // Top radix: single letter, carry into a second digit, "ZZ"
    set_base(6'd36);
    offer_value(63'd0);
    offer_value(63'd35);
    offer_value(63'd36);
    offer_value(63'd1295);
    offer_value(63'h7FFF_FFFF_FFFF_FFFF);
    wait_drained();

    set_base(6'd10);
    offer_value(63'd9);
    offer_value(63'd10);
    offer_value(63'd1000000000000000000);
    offer_value(63'h7FFF_FFFF_FFFF_FFFF);
    wait_drained();

    // Radix below range acts as 2, above range as 36
    set_base(6'd0);
    offer_value(63'd5);
    wait_drained();
    set_base(6'd1);
    offer_value(63'd6);
    wait_drained();
    set_base(6'd37);
    offer_value(63'd71);
    wait_drained();
    set_base(6'd63);
    offer_value(63'h7FFF_FFFF_FFFF_FFFF);
    wait_drained();

    set_base(6'd16);
    offer_value(63'h0123_4567_89AB_CDEF);
    offer_value(63'h7EDC_BA98_7654_3210);
    wait_drained();

    // Random phases, each under its own radix
    plan = '{36, 10, 16, 3, 0, 0, 2, 35};
    plan[4] = $urandom_range(2, 36);
    plan[5] = $urandom_range(0, 63);
    for (int p = 0; p < 8; p++) begin
      set_base(BASE_W'(plan[p]));
      if (p == 0) begin
        // Stall the receiver while requests keep coming so the block backs up
        hold_off_cycles = HOLD_CYCLES;
        no_gaps = 1'b1;
        for (int i = 0; i < 12; i++) begin
          offer_value(VALUE_BITS'($urandom_range(0, 999999)));
        end
      end
      no_gaps = (p == 2 || p == 5);
      for (int i = 0; i < 14; i++) begin
        if ($urandom_range(0, 14) == 0) begin
          wait_drained();
        end
        offer_value(random_value());
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("tb: %0d values converted to %0d digits under %0d radix settings",
             board.values_seen, board.digits_checked, bases_tried);
    $display("tb: included out-of-range radix values and a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (board.errors == 0 && board.pending_digits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
